[design/layer_coincidence_event_selector_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the layer coincidence event selector
// Shared shorthand for clocked assertions sampled on clk, muted in reset.
// ----------------------------------------------------------------------------
`ifndef LAYER_COINCIDENCE_EVENT_SELECTOR_CORE_MACROS_SVH
`define LAYER_COINCIDENCE_EVENT_SELECTOR_CORE_MACROS_SVH

// Same-cycle implication.
`define LCES_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("event selector assertion failed");

// Next-cycle implication.
`define LCES_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("event selector assertion failed");

`endif

[design/lces_pkg.sv]
// ----------------------------------------------------------------------------
// Layer coincidence event selector package
// Field widths, codes, reset values and the types shared by the modules.
// ----------------------------------------------------------------------------
package lces_pkg;

	localparam int ROW_W      = 3;
	localparam int COL_W      = 3;
	localparam int LAYER_W    = 4;
	localparam int KIND_W     = 2;
	localparam int PULSE_W    = 4;
	localparam int CHARGE_W   = 20;
	localparam int TIME_W     = 19;
	localparam int SPREAD_W   = 20;
	localparam int COUNT_W    = 8;
	localparam int NUM_LAYERS = 4;
	localparam int LSEL_W     = 2;
	localparam int BAR_IDX_W  = 7;
	localparam int MAP_SIZE_W = 9;

	localparam int S_TDATA_W  = 56;
	localparam int M_TDATA_W  = 112;
	localparam int M_USED_W   = 1 + COUNT_W + NUM_LAYERS * CHARGE_W + SPREAD_W;

	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	localparam int BAR_MAP_SIZE_DEF = 128;

	localparam logic [KIND_W-1:0] KIND_BAR   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PANEL = 2'd2;
	localparam logic CMD_HIT = 1'b0;
	localparam logic CMD_END = 1'b1;

	localparam logic [1:0] REG_PANEL_THR = 2'd0;
	localparam logic [1:0] REG_BAR_THR   = 2'd1;
	localparam logic [1:0] REG_COUNT_THR = 2'd2;
	localparam logic [1:0] REG_ROW_SEL   = 2'd3;

	localparam logic [CHARGE_W-1:0] PANEL_THR_RST = 20'd160000;
	localparam logic [CHARGE_W-1:0] BAR_THR_RST   = 20'd32;
	localparam logic [CHARGE_W-1:0] COUNT_THR_RST = 20'd16;
	localparam logic [ROW_W-1:0]    ROW_SEL_RST   = 3'd4;

	// 3000 ns in Q4.
	localparam logic signed [TIME_W-1:0] TIME_INIT = 19'sd48000;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

	typedef struct packed {
		logic [CHARGE_W-1:0] panel_thr;
		logic [CHARGE_W-1:0] bar_thr;
		logic [CHARGE_W-1:0] count_thr;
		logic [ROW_W-1:0]    row_sel;
	} cfg_t;

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		logic                       is_end;
		logic                       matched;
		logic [1:0]                 panel_hit;
		logic                       bar_hit;
		logic                       counted;
		logic [LSEL_W-1:0]          layer;
		logic [BAR_IDX_W-1:0]       idx;
		logic                       in_map;
		logic [CHARGE_W-1:0]        charge;
		logic signed [TIME_W-1:0]   hit_time;
	} entry_t;

	typedef struct packed {
		logic signed [SPREAD_W-1:0] time_spread;
		logic [CHARGE_W-1:0]        max3;
		logic [CHARGE_W-1:0]        max2;
		logic [CHARGE_W-1:0]        max1;
		logic [CHARGE_W-1:0]        max0;
		logic [COUNT_W-1:0]         distinct_bars;
		logic                       accepted;
	} result_t;

endpackage

[design/lces_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the three charge thresholds and the row.
// ----------------------------------------------------------------------------
module lces_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lces_pkg::APB_AW-1:0]       paddr,
	input  logic [lces_pkg::APB_DW-1:0]       pwdata,
	output logic [lces_pkg::APB_DW-1:0]       prdata,
	output logic                              pready,
	output lces_pkg::cfg_t                    cfg
);

	lces_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [1:0]     reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.panel_thr <= lces_pkg::PANEL_THR_RST;
			cfg_q.bar_thr   <= lces_pkg::BAR_THR_RST;
			cfg_q.count_thr <= lces_pkg::COUNT_THR_RST;
			cfg_q.row_sel   <= lces_pkg::ROW_SEL_RST;
		end else if (wr_en) begin
			case (reg_sel)
				lces_pkg::REG_PANEL_THR: cfg_q.panel_thr <= pwdata[lces_pkg::CHARGE_W-1:0];
				lces_pkg::REG_BAR_THR:   cfg_q.bar_thr   <= pwdata[lces_pkg::CHARGE_W-1:0];
				lces_pkg::REG_COUNT_THR: cfg_q.count_thr <= pwdata[lces_pkg::CHARGE_W-1:0];
				lces_pkg::REG_ROW_SEL:   cfg_q.row_sel   <= pwdata[lces_pkg::ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			lces_pkg::REG_PANEL_THR: prdata = lces_pkg::APB_DW'(cfg_q.panel_thr);
			lces_pkg::REG_BAR_THR:   prdata = lces_pkg::APB_DW'(cfg_q.bar_thr);
			lces_pkg::REG_COUNT_THR: prdata = lces_pkg::APB_DW'(cfg_q.count_thr);
			lces_pkg::REG_ROW_SEL:   prdata = lces_pkg::APB_DW'(cfg_q.row_sel);
			default:                 prdata = '0;
		endcase
	end

endmodule

[design/lces_front.sv]
// ----------------------------------------------------------------------------
// Input classifier
// Unpacks a hit record or end marker and reduces it to the flags the
// event state update needs.
// ----------------------------------------------------------------------------
module lces_front #(
	parameter int BAR_MAP_SIZE = lces_pkg::BAR_MAP_SIZE_DEF
) (
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [lces_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	input  logic                              s_axis_tuser,
	input  lces_pkg::cfg_t                    cfg,
	input  logic                              q_full,
	output logic                              q_push,
	output lces_pkg::entry_t                  q_entry
);

	logic [lces_pkg::ROW_W-1:0]    hit_row;
	logic [lces_pkg::COL_W-1:0]    hit_column;
	logic [lces_pkg::LAYER_W-1:0]  hit_layer;
	logic [lces_pkg::KIND_W-1:0]   hit_kind;
	logic [lces_pkg::PULSE_W-1:0]  pulse_number;
	logic [lces_pkg::CHARGE_W-1:0] charge;
	logic [lces_pkg::TIME_W-1:0]   hit_time;
	logic                          boards_matched;
	logic                          hit_ok;
	logic                          panel_ok;
	logic                          bar_ok;
	logic [lces_pkg::BAR_IDX_W-1:0] idx;

	assign hit_row        = s_axis_tdata[2:0];
	assign hit_column     = s_axis_tdata[5:3];
	assign hit_layer      = s_axis_tdata[9:6];
	assign hit_kind       = s_axis_tdata[11:10];
	assign pulse_number   = s_axis_tdata[15:12];
	assign charge         = s_axis_tdata[35:16];
	assign hit_time       = s_axis_tdata[54:36];
	assign boards_matched = s_axis_tdata[55];

	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid & s_axis_tready;

	assign hit_ok   = (s_axis_tuser == lces_pkg::CMD_HIT) && (pulse_number == '0);
	assign panel_ok = hit_ok && (hit_kind == lces_pkg::KIND_PANEL) &&
		(hit_row == cfg.row_sel) && (charge > cfg.panel_thr);
	// Negative layers show up as large raw codes and fall out here.
	assign bar_ok   = hit_ok && (hit_kind == lces_pkg::KIND_BAR) && (hit_layer[3:2] == 2'b00);

	assign idx = lces_pkg::BAR_IDX_W'(hit_row) +
		lces_pkg::BAR_IDX_W'({hit_column, 2'b00}) +
		lces_pkg::BAR_IDX_W'({hit_layer[1:0], 4'b0000});

	always_comb begin
		q_entry.is_end       = (s_axis_tuser == lces_pkg::CMD_END);
		q_entry.matched      = boards_matched;
		q_entry.panel_hit[0] = panel_ok && (hit_layer == 4'd0);
		q_entry.panel_hit[1] = panel_ok && (hit_layer == 4'd2);
		q_entry.bar_hit      = bar_ok && (charge > cfg.bar_thr);
		q_entry.counted      = bar_ok && (charge > cfg.count_thr);
		q_entry.layer        = hit_layer[1:0];
		q_entry.idx          = idx;
		q_entry.in_map       = lces_pkg::MAP_SIZE_W'(idx) < lces_pkg::MAP_SIZE_W'(BAR_MAP_SIZE);
		q_entry.charge       = charge;
		q_entry.hit_time     = $signed(hit_time);
	end

endmodule

[design/lces_queue.sv]
// ----------------------------------------------------------------------------
// Classified item queue
// Small FIFO that lets the classifier and the state update stall apart.
// ----------------------------------------------------------------------------
module lces_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lces_pkg::entry_t     push_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output lces_pkg::entry_t     head_entry
);

	lces_pkg::entry_t                mem_q [lces_pkg::QUEUE_DEPTH];
	logic [lces_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [lces_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [lces_pkg::QUEUE_AW:0]     count_q;

	assign full       = (count_q == (lces_pkg::QUEUE_AW+1)'(lces_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/lces_back.sv]
// ----------------------------------------------------------------------------
// Event state and result stage
// Folds classified hits into the per-event state and, on the end marker,
// forms the result in the output register and clears the state.
// ----------------------------------------------------------------------------
module lces_back #(
	parameter int BAR_MAP_SIZE = lces_pkg::BAR_MAP_SIZE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lces_pkg::cfg_t       cfg,
	input  logic                 head_valid,
	input  lces_pkg::entry_t     head_entry,
	output logic                 pop,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output lces_pkg::result_t    result
);

	localparam int MapAw = $clog2(BAR_MAP_SIZE);

	logic [1:0]                       panel_seen_q;
	logic [lces_pkg::NUM_LAYERS-1:0]  bar_seen_q;
	logic [lces_pkg::CHARGE_W-1:0]    max_q   [lces_pkg::NUM_LAYERS];
	logic signed [lces_pkg::TIME_W-1:0] early_q [lces_pkg::NUM_LAYERS];
	logic [BAR_MAP_SIZE-1:0]          bitmap_q;
	logic [lces_pkg::COUNT_W-1:0]     count_q;
	logic                             out_valid_q;
	lces_pkg::result_t                out_q;

	logic                             out_free;
	logic                             do_hit;
	logic                             do_end;
	logic [MapAw+lces_pkg::BAR_IDX_W-1:0] idx_wide;
	logic [MapAw-1:0]                 map_idx;
	logic                             new_bar;
	logic                             acc;
	logic [lces_pkg::LSEL_W-1:0]      lsel;
	lces_pkg::result_t                res_next;

	assign out_free = !out_valid_q || m_axis_tready;
	assign pop      = head_valid && (!head_entry.is_end || out_free);
	assign do_hit   = pop && !head_entry.is_end;
	assign do_end   = pop && head_entry.is_end;
	assign lsel     = head_entry.layer;

	assign idx_wide = {MapAw'(0), head_entry.idx};
	assign map_idx  = idx_wide[MapAw-1:0];
	assign new_bar  = head_entry.in_map && !bitmap_q[map_idx];

	assign acc = head_entry.matched && (bar_seen_q == '1) && (panel_seen_q != '0) &&
		(max_q[0] > cfg.bar_thr) && (max_q[1] > cfg.bar_thr) &&
		(max_q[2] > cfg.bar_thr) && (max_q[3] > cfg.bar_thr);

	always_comb begin
		res_next = '0;
		if (acc) begin
			res_next.accepted      = 1'b1;
			res_next.distinct_bars = count_q;
			res_next.max0          = max_q[0];
			res_next.max1          = max_q[1];
			res_next.max2          = max_q[2];
			res_next.max3          = max_q[3];
			res_next.time_spread   = {early_q[3][lces_pkg::TIME_W-1], early_q[3]} -
				{early_q[0][lces_pkg::TIME_W-1], early_q[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_seen_q <= '0;
			bar_seen_q   <= '0;
			bitmap_q     <= '0;
			count_q      <= '0;
			for (int k = 0; k < lces_pkg::NUM_LAYERS; k++) begin
				max_q[k]   <= '0;
				early_q[k] <= lces_pkg::TIME_INIT;
			end
		end else if (do_end) begin
			panel_seen_q <= '0;
			bar_seen_q   <= '0;
			bitmap_q     <= '0;
			count_q      <= '0;
			for (int k = 0; k < lces_pkg::NUM_LAYERS; k++) begin
				max_q[k]   <= '0;
				early_q[k] <= lces_pkg::TIME_INIT;
			end
		end else if (do_hit) begin
			panel_seen_q <= panel_seen_q | head_entry.panel_hit;
			if (head_entry.bar_hit) begin
				bar_seen_q[lsel] <= 1'b1;
			end
			if (head_entry.counted) begin
				if (new_bar) begin
					bitmap_q[map_idx] <= 1'b1;
					if (count_q != lces_pkg::COUNT_MAX) begin
						count_q <= count_q + 1'b1;
					end
				end
				if (head_entry.charge > max_q[lsel]) begin
					max_q[lsel] <= head_entry.charge;
				end
				if (head_entry.hit_time < early_q[lsel]) begin
					early_q[lsel] <= head_entry.hit_time;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_end) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_end) begin
			out_q <= res_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign result        = out_q;

endmodule

[design/layer_coincidence_event_selector_core.sv]
// ----------------------------------------------------------------------------
// Layer coincidence event selector
// Collects the hits of one event and reports acceptance and summary values
// at the end marker.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Payload
//  s_axis    in         tvalid/tready               hit record or end marker
//  m_axis    out        tvalid/tready               one result per end marker
//  apb       in/out     psel/penable/pwrite/pready  four configuration registers
//
// One item is taken per cycle; the state update handles one queue entry per
// cycle, so hits stream at full rate. A result is shown the cycle after its end
// marker leaves the four-entry queue and is captured in the output register.
// Reset loads the register defaults, clears the event state and empties the queue.
// A stalled output holds the next end marker at the queue head; the items behind
// it wait, and the input stalls once the queue holds four entries.
module layer_coincidence_event_selector_core #(
	parameter int BAR_MAP_SIZE = lces_pkg::BAR_MAP_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// hit_row, hit_column, hit_layer, hit_kind, pulse_number, charge, hit_time,
	// boards_matched
	input  logic [lces_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// command
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// accepted, distinct_bars, max_charge_layer0..3, time_spread, zero pad
	output logic [lces_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lces_pkg::APB_AW-1:0]     paddr,
	input  logic [lces_pkg::APB_DW-1:0]     pwdata,
	output logic [lces_pkg::APB_DW-1:0]     prdata,
	output logic                            pready
);

	lces_pkg::cfg_t    cfg;
	lces_pkg::entry_t  push_entry;
	lces_pkg::entry_t  head_entry;
	lces_pkg::result_t result;
	logic              q_full;
	logic              q_push;
	logic              q_pop;
	logic              head_valid;

	lces_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lces_front #(
		.BAR_MAP_SIZE (BAR_MAP_SIZE)
	) u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg           (cfg),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_entry       (push_entry)
	);

	lces_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	lces_back #(
		.BAR_MAP_SIZE (BAR_MAP_SIZE)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.head_valid    (head_valid),
		.head_entry    (head_entry),
		.pop           (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.result        (result)
	);

	assign m_axis_tdata = lces_pkg::M_TDATA_W'(result);

endmodule

[design/lces_checker.sv]
// ----------------------------------------------------------------------------
// Port checker for the event selector
// Watches the top-level ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
`include "layer_coincidence_event_selector_core_macros.svh"

module lces_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [lces_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

	logic out_acc;
	logic out_rej;
	logic out_wait;
	logic maxes_set;

	assign out_acc   = m_axis_tvalid && m_axis_tdata[0];
	assign out_rej   = m_axis_tvalid && !m_axis_tdata[0];
	assign out_wait  = m_axis_tvalid && !m_axis_tready;
	assign maxes_set = (m_axis_tdata[28:9] != '0) && (m_axis_tdata[48:29] != '0) &&
		(m_axis_tdata[68:49] != '0) && (m_axis_tdata[88:69] != '0);

	// A result waiting on the sink keeps its contents.
	`LCES_ASSERT_NXT(a_out_hold, out_wait, m_axis_tvalid && $stable(m_axis_tdata))

	// A rejected event reports all summary fields as zero.
	`LCES_ASSERT_IMP(a_reject_zero, out_rej, m_axis_tdata[lces_pkg::M_TDATA_W-1:1] == '0)

	// An accepted event had a counted bar charge in every layer.
	`LCES_ASSERT_IMP(a_accept_max, out_acc, maxes_set)

	// An accepted event carries at least one distinct bar.
	`LCES_ASSERT_IMP(a_accept_count, out_acc, m_axis_tdata[8:1] != '0)

endmodule

bind layer_coincidence_event_selector_core lces_checker u_lces_checker (.*);
